// ----- hw/rtl/ttb_pkg.sv -----
// Shared types, widths and helpers for the triangle tangent/bitangent block.
package ttb_pkg;

  localparam int unsigned CoordW   = 16;             // Q4.12 input coordinates
  localparam int unsigned DeltaW   = CoordW + 1;     // edge and UV deltas
  localparam int unsigned ProdW    = 2 * DeltaW;     // one delta product
  localparam int unsigned SumW     = ProdW + 1;      // difference of two products
  localparam int unsigned MagW     = SumW - 1;       // magnitude of a SumW value
  localparam int unsigned FracBits = 16;             // 1.0 in Q16.16
  localparam int unsigned NumerW   = MagW + FracBits + 1;  // 2*|n|*2^16 + |d|
  localparam int unsigned ResW     = 32;             // Q16.16 result
  localparam int unsigned NumSlots = 7;              // det, three tangent, three bitangent
  localparam int unsigned NumLanes = 6;
  localparam int unsigned QueueDepthDef = 2;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DeltaW-1:0] delta_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic signed [ResW-1:0]   result_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    coord_t tex_u;
    coord_t tex_v;
  } in_item_t;

  typedef struct packed {
    result_t tan_x;
    result_t tan_y;
    result_t tan_z;
    result_t bitan_x;
    result_t bitan_y;
    result_t bitan_z;
    logic    degenerate;
  } out_item_t;

  // Edges and UV deltas of one triangle, relative to its first vertex.
  typedef struct packed {
    delta_t e1x;
    delta_t e1y;
    delta_t e1z;
    delta_t e2x;
    delta_t e2y;
    delta_t e2z;
    delta_t d1u;
    delta_t d1v;
    delta_t d2u;
    delta_t d2v;
  } job_t;

  // Command from the back-end sequencer to each divider lane.
  typedef enum logic [2:0] {
    LaneIdle,
    LaneLoad,
    LaneForm,
    LaneCheck,
    LaneStep
  } lane_op_e;

  function automatic delta_t coord_diff(coord_t a, coord_t b);
    return delta_t'(a) - delta_t'(b);
  endfunction

  function automatic logic [MagW-1:0] sum_mag(sum_t v);
    sum_t n;
    n = v[SumW-1] ? -v : v;
    return n[MagW-1:0];
  endfunction

endpackage

// ----- hw/rtl/ttb_front.sv -----
// Front end: vertex intake, holding of the first two vertices, edge and delta forming.
module ttb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  ttb_pkg::in_item_t item_i,
  output logic              job_push_o,
  input  logic              job_full_i,
  output ttb_pkg::job_t     job_o
);
  import ttb_pkg::*;

  localparam logic [1:0] PhFirst  = 2'd0;
  localparam logic [1:0] PhSecond = 2'd1;
  localparam logic [1:0] PhThird  = 2'd2;

  logic [1:0] phase_q, phase_d;
  in_item_t   hold0_q, hold1_q;
  logic       accept;
  logic       third;

  assign third      = (phase_q == PhThird);
  assign full_o     = third && job_full_i;
  assign accept     = push_i && !full_o;
  assign job_push_o = accept && third;

  always_comb begin
    job_o.e1x = coord_diff(hold1_q.pos_x, hold0_q.pos_x);
    job_o.e1y = coord_diff(hold1_q.pos_y, hold0_q.pos_y);
    job_o.e1z = coord_diff(hold1_q.pos_z, hold0_q.pos_z);
    job_o.e2x = coord_diff(item_i.pos_x, hold0_q.pos_x);
    job_o.e2y = coord_diff(item_i.pos_y, hold0_q.pos_y);
    job_o.e2z = coord_diff(item_i.pos_z, hold0_q.pos_z);
    job_o.d1u = coord_diff(hold1_q.tex_u, hold0_q.tex_u);
    job_o.d1v = coord_diff(hold1_q.tex_v, hold0_q.tex_v);
    job_o.d2u = coord_diff(item_i.tex_u, hold0_q.tex_u);
    job_o.d2v = coord_diff(item_i.tex_v, hold0_q.tex_v);
  end

  // unused phase code behaves as the first vertex
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (phase_q)
        PhSecond: phase_d = PhThird;
        PhThird:  phase_d = PhFirst;
        default:  phase_d = PhSecond;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFirst;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (phase_q == PhSecond)) begin
      hold1_q <= item_i;
    end
    if (accept && (phase_q != PhSecond) && !third) begin
      hold0_q <= item_i;
    end
  end

endmodule

// ----- hw/rtl/ttb_job_fifo.sv -----
// Short queue of triangle jobs between the front and back ends.
module ttb_job_fifo #(
  parameter int unsigned Depth = ttb_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  ttb_pkg::job_t data_i,
  input  logic          pop_i,
  output logic          empty_o,
  output ttb_pkg::job_t data_o
);
  import ttb_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- hw/rtl/ttb_div_lane.sv -----
// One divider lane: rounded, saturated Q16.16 quotient, one quotient bit per step.
module ttb_div_lane (
  input  logic              clk_i,
  input  ttb_pkg::lane_op_e op_i,
  input  ttb_pkg::sum_t     num_i,
  input  ttb_pkg::sum_t     det_i,
  output ttb_pkg::result_t  quo_o
);
  import ttb_pkg::*;

  localparam result_t PosMax = {1'b0, {(ResW-1){1'b1}}};
  localparam result_t NegMin = {1'b1, {(ResW-1){1'b0}}};
  localparam int unsigned TopW = NumerW - ResW;

  logic [MagW-1:0]   an_q, ad_q;
  logic              neg_q;
  logic [MagW:0]     rem_q;   // stays below the divisor once past the check
  logic [ResW-1:0]   low_q, quo_q;
  logic              ovf_q;

  logic [MagW:0]     den;
  logic [NumerW-1:0] numer;
  logic [MagW+1:0]   shifted, trial;

  // q = floor((2|n|*2^16 + |d|) / (2|d|)) rounds half away from zero
  assign den     = {ad_q, 1'b0};
  assign numer   = {an_q, {(FracBits+1){1'b0}}} + {{(NumerW-MagW){1'b0}}, ad_q};
  assign shifted = {rem_q, low_q[ResW-1]};
  assign trial   = shifted - {1'b0, den};

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      LaneLoad: begin
        an_q  <= sum_mag(num_i);
        ad_q  <= sum_mag(det_i);
        neg_q <= num_i[SumW-1] ^ det_i[SumW-1];
      end
      LaneForm: begin
        rem_q <= {{(MagW+1-TopW){1'b0}}, numer[NumerW-1:ResW]};
        low_q <= numer[ResW-1:0];
        quo_q <= '0;
      end
      LaneCheck: begin
        // quotient of 2^32 or more: saturate whatever the sign
        ovf_q <= (rem_q >= den);
      end
      LaneStep: begin
        rem_q <= trial[MagW+1] ? shifted[MagW:0] : trial[MagW:0];
        low_q <= {low_q[ResW-2:0], 1'b0};
        quo_q <= {quo_q[ResW-2:0], ~trial[MagW+1]};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (!neg_q) begin
      quo_o = (ovf_q || quo_q[ResW-1]) ? PosMax : result_t'(quo_q);
    end else if (ovf_q || (quo_q[ResW-1] && (|quo_q[ResW-2:0]))) begin
      quo_o = NegMin;
    end else begin
      quo_o = -result_t'(quo_q);
    end
  end

endmodule

// ----- hw/rtl/ttb_back.sv -----
// Back end: determinant and numerators on two multipliers, then six divider lanes.
module ttb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_empty_i,
  output logic               job_pop_o,
  input  ttb_pkg::job_t      job_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output ttb_pkg::out_item_t res_o
);
  import ttb_pkg::*;

  localparam int unsigned StepW = $clog2(NumSlots + 1);
  localparam int unsigned DivW  = $clog2(ResW);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMul   = 3'd1;
  localparam logic [2:0] StLoad  = 3'd2;
  localparam logic [2:0] StForm  = 3'd3;
  localparam logic [2:0] StCheck = 3'd4;
  localparam logic [2:0] StDiv   = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  localparam logic [StepW-1:0] SlotDet  = StepW'(0);
  localparam logic [StepW-1:0] SlotTanX = StepW'(1);
  localparam logic [StepW-1:0] SlotTanY = StepW'(2);
  localparam logic [StepW-1:0] SlotTanZ = StepW'(3);
  localparam logic [StepW-1:0] SlotBitX = StepW'(4);
  localparam logic [StepW-1:0] SlotBitY = StepW'(5);
  localparam logic [StepW-1:0] SlotBitZ = StepW'(6);
  localparam logic [StepW-1:0] StepEnd  = StepW'(NumSlots);
  localparam logic [DivW-1:0]  DivLast  = DivW'(ResW - 1);

  logic [2:0]       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [DivW-1:0]  div_cnt_q, div_cnt_d;

  job_t     job_q;
  prod_t    prod_a_q, prod_b_q;
  sum_t     num_q [NumSlots];
  delta_t   op_a, op_b, op_c, op_d;
  lane_op_e lane_op;
  result_t  quo [NumLanes];
  logic     det_zero;

  assign job_pop_o   = (state_q == StIdle) && !job_empty_i;
  assign res_valid_o = (state_q == StDone);
  assign det_zero    = (num_q[SlotDet] == '0);

  // det = d1u*d2v - d1v*d2u, tan = e1*d2v - e2*d1v, bitan = e2*d1u - e1*d2u
  always_comb begin
    unique case (step_q)
      SlotTanX: begin op_a = job_q.e1x; op_b = job_q.d2v; op_c = job_q.e2x; op_d = job_q.d1v; end
      SlotTanY: begin op_a = job_q.e1y; op_b = job_q.d2v; op_c = job_q.e2y; op_d = job_q.d1v; end
      SlotTanZ: begin op_a = job_q.e1z; op_b = job_q.d2v; op_c = job_q.e2z; op_d = job_q.d1v; end
      SlotBitX: begin op_a = job_q.e2x; op_b = job_q.d1u; op_c = job_q.e1x; op_d = job_q.d2u; end
      SlotBitY: begin op_a = job_q.e2y; op_b = job_q.d1u; op_c = job_q.e1y; op_d = job_q.d2u; end
      SlotBitZ: begin op_a = job_q.e2z; op_b = job_q.d1u; op_c = job_q.e1z; op_d = job_q.d2u; end
      default:  begin op_a = job_q.d1u; op_b = job_q.d2v; op_c = job_q.d1v; op_d = job_q.d2u; end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    div_cnt_d = div_cnt_q;
    lane_op   = LaneIdle;
    unique case (state_q)
      StIdle: begin
        step_d = '0;
        if (!job_empty_i) begin
          state_d = StMul;
        end
      end
      StMul: begin
        step_d = step_q + 1'b1;
        if (step_q == StepEnd) begin
          state_d = StLoad;
        end
      end
      StLoad: begin
        lane_op = LaneLoad;
        state_d = StForm;
      end
      StForm: begin
        lane_op = LaneForm;
        state_d = StCheck;
      end
      StCheck: begin
        lane_op   = LaneCheck;
        div_cnt_d = '0;
        state_d   = StDiv;
      end
      StDiv: begin
        lane_op   = LaneStep;
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DivLast) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      step_q    <= '0;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  // products of step k are registered, and their difference lands in slot k during the next step
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    if (state_q == StMul) begin
      prod_a_q <= op_a * op_b;
      prod_b_q <= op_c * op_d;
      if (step_q != SlotDet) begin
        num_q[step_q - 1'b1] <= sum_t'(prod_a_q) - sum_t'(prod_b_q);
      end
    end
  end

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    ttb_div_lane u_lane (
      .clk_i (clk_i),
      .op_i  (lane_op),
      .num_i (num_q[i+1]),
      .det_i (num_q[SlotDet]),
      .quo_o (quo[i])
    );
  end

  always_comb begin
    if (det_zero) begin
      res_o            = '0;
      res_o.degenerate = 1'b1;
    end else begin
      res_o.tan_x      = quo[0];
      res_o.tan_y      = quo[1];
      res_o.tan_z      = quo[2];
      res_o.bitan_x    = quo[3];
      res_o.bitan_y    = quo[4];
      res_o.bitan_z    = quo[5];
      res_o.degenerate = 1'b0;
    end
  end

endmodule

// ----- hw/rtl/triangle_tangent_bitangent.sv -----
// Triangle tangent/bitangent top level: front end, job queue, back end, result register.
//
// Usage notes
// - Input channel (push/full): one vertex per transaction, position and UV in signed Q4.12.
//   Vertices come in threes; every third vertex closes a triangle.
// - Result channel (empty/pop): one transaction per triangle carrying tangent and bitangent
//   in saturated Q16.16, plus a degenerate flag (zero UV determinant, vectors zero).
// - The first two vertices of a triangle are taken whenever offered. The third is taken as
//   soon as the job queue has room; full only rises on a third vertex with the queue full.
// - Back end: one triangle at a time, in turn on the two shared multipliers, operand set-up
//   and range check, the bit-serial divider lanes, then handing the result over and picking
//   up the next job. The six components divide in parallel lanes.
// - Stalls: a finished result sits in the output register; the back end starts the next
//   triangle as soon as that register frees up, and the queue keeps taking triangles meanwhile.
// - Reset (rst_ni low, asynchronous): queue and result register emptied, vertex count back to
//   the first vertex of a triangle. Held vertices are not cleared; they are always rewritten
//   before use.
module triangle_tangent_bitangent #(
  parameter int unsigned QueueDepth = ttb_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  ttb_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output ttb_pkg::out_item_t out_item_o
);
  import ttb_pkg::*;

  logic      job_push, job_full, job_pop, job_empty;
  job_t      job_in, job_out;
  logic      res_valid, res_ready;
  out_item_t res;

  logic      out_vld_q;
  out_item_t out_q;

  ttb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .item_i     (in_item_i),
    .job_push_o (job_push),
    .job_full_i (job_full),
    .job_o      (job_in)
  );

  ttb_job_fifo #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .full_o  (job_full),
    .data_i  (job_in),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .data_o  (job_out)
  );

  ttb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .job_i       (job_out),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // single-entry result register; refills in the same cycle it is popped
  assign res_ready  = !out_vld_q || pop;
  assign empty      = !out_vld_q;
  assign out_item_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_q <= 1'b1;
    end else if (pop) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

endmodule

// ----- tb/sv/triangle_tangent_bitangent_test.sv -----
// Self-checking testbench for the triangle tangent/bitangent block.
`timescale 1ns / 1ps

module triangle_tangent_bitangent_test;
  import ttb_pkg::*;

  // Run limits and timing knobs
  localparam int unsigned CycleLimit  = 400_000;  // far above the slowest correct run
  localparam int unsigned RandTris    = 542;      // random triangles after the directed table
  localparam int unsigned HoldCycles  = 800;      // long receiver hold-off, fills the block
  localparam int unsigned DrainCycles = 120;      // settle time after the last result
  localparam int unsigned MaxPrints   = 40;       // cap on mismatch lines

  // Corner index of the vertex that closes a triangle
  localparam logic [1:0] LastCorner = 2'd2;

  // Handy coordinate and result values
  localparam int      QMax   = 32767;
  localparam int      QMin   = -32768;
  localparam result_t SatPos = 32'sh7FFF_FFFF;
  localparam result_t SatNeg = 32'sh8000_0000;

  // DUT connections, all inputs known from time zero
  logic      clk_i   = 1'b0;
  logic      rst_ni  = 1'b0;
  logic      push    = 1'b0;
  logic      pop     = 1'b0;
  in_item_t  in_item = '0;
  logic      full;
  logic      empty;
  out_item_t out_item;

  triangle_tangent_bitangent u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  // One row of the directed table: a vertex, plus an expected result typed in by hand
  // where it can be read straight off the maths (only used on a closing vertex).
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } row_t;

  row_t      dir_tab[$];
  out_item_t tri_expect_q[$];   // expected triangle results, oldest first
  in_item_t  tri_buf[3];        // vertices of the next random triangle

  // Private copy of the block state for prediction
  coord_t     held_pos[2][3];
  coord_t     held_uv[2][2];
  logic [1:0] corner = 2'd0;

  int unsigned n_errors     = 0;
  int unsigned n_results    = 0;
  int unsigned n_vertices   = 0;
  int unsigned n_triangles  = 0;
  int unsigned n_degenerate = 0;
  int unsigned n_saturated  = 0;
  int unsigned n_cycles     = 0;
  int unsigned burst_left   = 0;

  //--------------------------------------------------------------------------
  // Clock and reset
  //--------------------------------------------------------------------------
  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  initial begin : reset_gen
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog: a hang or a lost result ends the run here
  always @(posedge clk_i) begin : watchdog
    n_cycles <= n_cycles + 1;
    if (n_cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               n_cycles, tri_expect_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  //--------------------------------------------------------------------------
  // Predictor
  //--------------------------------------------------------------------------

  // round(num * 2^16 / den), ties away from zero, saturated to Q16.16; den is non-zero
  function automatic result_t q16_div(longint num, longint den);
    bit              neg;
    longint unsigned an;
    longint unsigned ad;
    longint unsigned q;
    neg = (num < 0) != (den < 0);
    an  = (num < 0) ? -num : num;
    an  = an << FracBits;
    ad  = (den < 0) ? -den : den;
    q   = (64'd2 * an + ad) / (64'd2 * ad);
    if (!neg) begin
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return result_t'(q[31:0]);
    end
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    q = -q;
    return result_t'(q[31:0]);
  endfunction

  // Feeds one vertex to the private state; on the closing vertex returns the triangle result
  task automatic predict_vertex(input in_item_t v, output bit has_res, output out_item_t res);
    longint  p[3];
    longint  e1[3];
    longint  e2[3];
    longint  d1u, d1v, d2u, d2v, det;
    result_t tv[3];
    result_t bv[3];
    int      k;
    p[0]    = v.pos_x;
    p[1]    = v.pos_y;
    p[2]    = v.pos_z;
    has_res = 1'b0;
    res     = '0;
    if (corner > LastCorner) corner = 2'd0;
    if (corner != LastCorner) begin
      held_pos[corner][0] = v.pos_x;
      held_pos[corner][1] = v.pos_y;
      held_pos[corner][2] = v.pos_z;
      held_uv[corner][0]  = v.tex_u;
      held_uv[corner][1]  = v.tex_v;
      corner = corner + 2'd1;
    end else begin
      corner  = 2'd0;
      has_res = 1'b1;
      for (k = 0; k < 3; k++) begin
        e1[k] = longint'(held_pos[1][k]) - longint'(held_pos[0][k]);
        e2[k] = p[k] - longint'(held_pos[0][k]);
      end
      d1u = longint'(held_uv[1][0]) - longint'(held_uv[0][0]);
      d1v = longint'(held_uv[1][1]) - longint'(held_uv[0][1]);
      d2u = longint'(v.tex_u) - longint'(held_uv[0][0]);
      d2v = longint'(v.tex_v) - longint'(held_uv[0][1]);
      det = d1u * d2v - d1v * d2u;
      if (det == 0) begin
        res.degenerate = 1'b1;
      end else begin
        for (k = 0; k < 3; k++) begin
          tv[k] = q16_div(e1[k] * d2v - e2[k] * d1v, det);
          bv[k] = q16_div(e2[k] * d1u - e1[k] * d2u, det);
        end
        res.tan_x   = tv[0];
        res.tan_y   = tv[1];
        res.tan_z   = tv[2];
        res.bitan_x = bv[0];
        res.bitan_y = bv[1];
        res.bitan_z = bv[2];
      end
    end
  endtask

  //--------------------------------------------------------------------------
  // Stimulus helpers
  //--------------------------------------------------------------------------

  function automatic out_item_t out_vec(result_t tx, result_t ty, result_t tz,
                                        result_t bx, result_t by, result_t bz, logic deg);
    out_item_t o;
    o.tan_x      = tx;
    o.tan_y      = ty;
    o.tan_z      = tz;
    o.bitan_x    = bx;
    o.bitan_y    = by;
    o.bitan_z    = bz;
    o.degenerate = deg;
    return o;
  endfunction

  task automatic add_row(int px, int py, int pz, int u, int v, bit typed, out_item_t want);
    row_t r;
    r.item.pos_x = coord_t'(px);
    r.item.pos_y = coord_t'(py);
    r.item.pos_z = coord_t'(pz);
    r.item.tex_u = coord_t'(u);
    r.item.tex_v = coord_t'(v);
    r.typed      = typed;
    r.want       = want;
    dir_tab      = {dir_tab, r};
  endtask

  // Directed table: eight triangles covering the awkward corners of the arithmetic
  task automatic build_directed();
    out_item_t none;
    out_item_t flat;
    none = '0;
    flat = out_vec(0, 0, 0, 0, 0, 0, 1'b1);
    // straight after reset: all UVs equal, zero determinant
    add_row(0,    0,    0, 0, 0, 0, none);
    add_row(4096, 0,    0, 0, 0, 0, none);
    add_row(0,    4096, 0, 0, 0, 1, flat);
    // unit UV square in Q4.12
    add_row(0,    0,    0, 0,    0,    0, none);
    add_row(4096, 0,    0, 4096, 0,    0, none);
    add_row(0,    4096, 0, 0,    4096, 0, none);
    // full-range edge over a one-LSB UV step: tangent clips both ways
    add_row(QMin, QMax, 0, 0, 0, 0, none);
    add_row(QMax, QMin, 0, 1, 0, 0, none);
    add_row(QMin, QMax, 0, 0, 1, 1, out_vec(SatPos, SatNeg, 0, 0, 0, 0, 1'b0));
    // swapped UV axes, determinant minus one
    add_row(0, 0,    0,    0, 0, 0, none);
    add_row(QMax, 0, QMin, 0, 1, 0, none);
    add_row(0, QMin, QMax, 1, 0, 0, none);
    // collinear but non-zero UV deltas, still degenerate
    add_row(QMax, QMax, QMax, 100,  200,  0, none);
    add_row(QMin, QMin, QMin, 300,  600,  0, none);
    add_row(QMax, QMin, 0,    -100, -200, 1, flat);
    // UV extremes, largest determinant
    add_row(QMin, 0,  QMax, QMin, QMin, 0, none);
    add_row(1,    -1, 2,    QMax, QMin, 0, none);
    add_row(-2,   3,  QMin, QMin, QMax, 0, none);
    // exact half on a negative bitangent component: rounds away from zero
    add_row(0,    0,     0, -16384, -16384, 0, none);
    add_row(8192, -8192, 0, 16384,  -16384, 0, none);
    add_row(0,    0,     0, -16383, 16384,  0, none);
    // every field at an extreme on the first two vertices, small values on the third
    add_row(QMax, QMax, QMax, QMax, QMax, 0, none);
    add_row(QMin, QMin, QMin, QMin, QMin, 0, none);
    add_row(-1,   0,    1,    -1,   1,    0, none);
  endtask

  // mode 0 full range, 1 small, 2 extremes, 3 a random mix per field
  function automatic coord_t rand_coord(int unsigned mode);
    int unsigned m;
    m = (mode == 3) ? $urandom_range(0, 2) : mode;
    case (m)
      0: return coord_t'($urandom);
      1: return coord_t'(int'($urandom_range(0, 2048)) - 1024);
      default: begin
        case ($urandom_range(0, 4))
          0:       return coord_t'(QMin);
          1:       return coord_t'(QMax);
          2:       return coord_t'(-1);
          3:       return coord_t'(1);
          default: return coord_t'(0);
        endcase
      end
    endcase
  endfunction

  // Fills tri_buf with one random triangle; about one in ten is forced flat in UV
  task automatic make_triangle();
    int unsigned pos_mode;
    int unsigned uv_mode;
    int          k;
    pos_mode = $urandom_range(0, 3);
    uv_mode  = $urandom_range(0, 3);
    for (k = 0; k < 3; k++) begin
      tri_buf[k].pos_x = rand_coord(pos_mode);
      tri_buf[k].pos_y = rand_coord(pos_mode);
      tri_buf[k].pos_z = rand_coord(pos_mode);
      tri_buf[k].tex_u = rand_coord(uv_mode);
      tri_buf[k].tex_v = rand_coord(uv_mode);
    end
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          tri_buf[2].tex_u = tri_buf[0].tex_u;
          tri_buf[2].tex_v = tri_buf[0].tex_v;
        end
        1: begin
          tri_buf[1].tex_u = tri_buf[0].tex_u;
          tri_buf[1].tex_v = tri_buf[0].tex_v;
        end
        2: begin
          tri_buf[2].tex_u = tri_buf[1].tex_u;
          tri_buf[2].tex_v = tri_buf[1].tex_v;
        end
        default: begin
          // same u on all three vertices: both u deltas vanish
          tri_buf[1].tex_u = tri_buf[0].tex_u;
          tri_buf[2].tex_u = tri_buf[0].tex_u;
        end
      endcase
    end
  endtask

  // Offers one vertex, called at a falling edge. Bursts of random length with
  // random gaps between them; the transaction completes on a rising edge with
  // push high and full low, and the task returns on the following falling edge.
  task automatic offer_vertex(input in_item_t item, input bit typed, input out_item_t want);
    int unsigned gap;
    bit          has_res;
    out_item_t   res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    push    <= 1'b1;
    in_item <= item;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    n_vertices++;
    predict_vertex(item, has_res, res);
    if (has_res) begin
      if (typed) res = want;
      tri_expect_q = {tri_expect_q, res};
      n_triangles++;
      if (res.degenerate) n_degenerate++;
      if (res.tan_x inside {SatPos, SatNeg} || res.tan_y inside {SatPos, SatNeg} ||
          res.tan_z inside {SatPos, SatNeg} || res.bitan_x inside {SatPos, SatNeg} ||
          res.bitan_y inside {SatPos, SatNeg} || res.bitan_z inside {SatPos, SatNeg})
        n_saturated++;
    end
    @(negedge clk_i);
  endtask

  //--------------------------------------------------------------------------
  // Sender: directed table, then random triangles, then drain and verdict
  //--------------------------------------------------------------------------
  initial begin : sender
    int t;
    int k;
    @(posedge rst_ni);
    @(negedge clk_i);
    build_directed();
    foreach (dir_tab[k]) offer_vertex(dir_tab[k].item, dir_tab[k].typed, dir_tab[k].want);
    for (t = 0; t < RandTris; t++) begin
      make_triangle();
      for (k = 0; k < 3; k++) offer_vertex(tri_buf[k], 1'b0, '0);
    end
    push <= 1'b0;
    // every expected result must come back; the watchdog catches the rest
    while (tri_expect_q.size() != 0) @(posedge clk_i);
    // a late spare result would show up as unexpected here
    repeat (DrainCycles) @(posedge clk_i);
    $display("run covered %0d vertices, %0d triangles: %0d degenerate, %0d clipped",
             n_vertices, n_triangles, n_degenerate, n_saturated);
    $display("receiver held off twice for %0d cycles with the sender still pushing; %0d cycles",
             HoldCycles, n_cycles);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("FAILURE");
    end
    $finish;
  end

  //--------------------------------------------------------------------------
  // Receiver: its own stall pattern, plus two long hold-offs to back the block up
  //--------------------------------------------------------------------------
  initial begin : receiver
    int unsigned mode;
    int unsigned left;
    bit          held_early;
    bit          held_late;
    mode       = 0;
    left       = 0;
    held_early = 1'b0;
    held_late  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ((!held_early && n_results >= 30) || (!held_late && n_results >= 300)) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        if (!held_early) held_early = 1'b1;
        else             held_late  = 1'b1;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(16, 200);
      end
      left--;
      case (mode)
        0:       pop <= 1'b1;
        1:       pop <= 1'($urandom_range(0, 1));
        default: pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Result checking
  //--------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    n_errors++;
    if (n_errors <= MaxPrints) $display("result %0d: %s", n_results, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %08h, want %08h", name, got, want));
  endtask

  always @(posedge clk_i) begin : result_monitor
    out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (tri_expect_q.size() == 0) begin
        report_mismatch("transaction with no triangle outstanding");
      end else begin
        want = tri_expect_q.pop_front();
        check_field("tan_x",      out_item.tan_x,      want.tan_x);
        check_field("tan_y",      out_item.tan_y,      want.tan_y);
        check_field("tan_z",      out_item.tan_z,      want.tan_z);
        check_field("bitan_x",    out_item.bitan_x,    want.bitan_x);
        check_field("bitan_y",    out_item.bitan_y,    want.bitan_y);
        check_field("bitan_z",    out_item.bitan_z,    want.bitan_z);
        check_field("degenerate", 32'(out_item.degenerate), 32'(want.degenerate));
      end
      n_results++;
    end
  end

endmodule
